FILE: hdl/sdq_pkg.sv
// Shared types and constants for the sorted double-ended queue.
// Holds the request and status codes and the command beat format.
// No dependencies.
package sdq_pkg;

  // Store geometry.
  localparam int DEPTH = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CW-1:0] count_t;
  typedef logic [IW-1:0] index_t;

  // Requests after decoding.
  typedef enum logic [1:0] {
    OP_INSERT       = 2'd0,
    OP_POP_FIRST    = 2'd1,
    OP_POP_LAST     = 2'd2,
    OP_REMOVE_VALUE = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // One command beat between the front end and the cell array.
  typedef struct packed {
    op_t   op;
    data_t value;
  } cmd_t;

endpackage

FILE: hdl/sdq_front.sv
// Front end of the sorted double-ended queue: accepts and decodes requests.
// Depends on sdq_pkg; feeds sdq_fifo.
module sdq_front import sdq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic signed [31:0] in_value,
  output logic        push,
  output cmd_t        push_cmd,
  input  logic        fifo_full
);

  logic valid_r;
  logic valid_nxt;
  cmd_t cmd_r;
  op_t  op_dec;
  logic accept;

  // Map the request code onto the internal operation.
  always_comb begin
    case (in_req_type)
      2'd0:    op_dec = OP_INSERT;
      2'd1:    op_dec = OP_POP_FIRST;
      2'd2:    op_dec = OP_POP_LAST;
      default: op_dec = OP_REMOVE_VALUE;
    endcase
  end

  // The held beat moves on whenever the queue has room.
  assign push      = valid_r && !fifo_full;
  assign push_cmd  = cmd_r;
  assign busy      = valid_r && fifo_full;
  assign accept    = start && !busy;
  assign valid_nxt = accept || (valid_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.op    <= op_dec;
      cmd_r.value <= data_t'(in_value);
    end
  end

endmodule

FILE: hdl/sdq_fifo.sv
// Two-beat command queue between the front end and the cell array.
// Depends on sdq_pkg.
module sdq_fifo import sdq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic not_empty,
  input  logic pop,
  output cmd_t head
);

  cmd_t       mem [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign head      = mem[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hdl/sdq_back.sv
// Back end of the sorted double-ended queue: a row of cells that compare
// and shift in parallel, plus the result registers. Depends on sdq_pkg.
module sdq_back import sdq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_removed_value,
  output logic [4:0]  out_entry_count,
  output logic signed [31:0] out_first_value,
  output logic signed [31:0] out_last_value
);

  data_t     ent_r   [DEPTH];
  data_t     ent_nxt [DEPTH];
  data_t     ent_prev[DEPTH];
  data_t     ent_next[DEPTH];
  count_t    cnt_r;
  count_t    cnt_nxt;
  logic      valid_bits[DEPTH];
  logic [DEPTH-1:0] le;
  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] eq;
  logic [DEPTH-1:0] le_prev;
  logic      out_valid_r;
  status_t   status_r;
  status_t   status_nxt;
  data_t     removed_r;
  data_t     removed_nxt;
  data_t     last_ent;
  data_t     v;

  assign v = cmd.value;

  // Per-cell compare flags against the command value.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_bits[i] = (count_t'(i) < cnt_r);
      le[i] = valid_bits[i] && ($signed(ent_r[i]) <= $signed(v));
      ge[i] = valid_bits[i] && ($signed(ent_r[i]) >= $signed(v));
      eq[i] = valid_bits[i] && (ent_r[i] == v);
    end
  end

  // Neighbor taps for shifting up and down the row.
  for (genvar g = 0; g < DEPTH; g++) begin : g_taps
    if (g == 0) begin : g_first
      assign ent_prev[g] = v;
      assign le_prev[g]  = 1'b0;
    end else begin : g_mid
      assign ent_prev[g] = ent_r[g-1];
      assign le_prev[g]  = le[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign ent_next[g] = ent_r[g];
    end else begin : g_body
      assign ent_next[g] = ent_r[g+1];
    end
  end

  assign last_ent = ent_r[index_t'(cnt_r - count_t'(1))];

  // Cell update for one command.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    cnt_nxt     = cnt_r;
    status_nxt  = ST_OK;
    removed_nxt = '0;
    case (cmd.op)
      OP_INSERT: begin
        if (cnt_r == count_t'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          // Entries at or below the value stay; the first cell above takes
          // the value and the rest move up one place.
          for (int i = 0; i < DEPTH; i++) begin
            if (!le[i]) begin
              ent_nxt[i] = le_prev[i] || (i == 0) ? v : ent_prev[i];
            end
          end
          cnt_nxt = cnt_r + count_t'(1);
        end
      end
      OP_POP_FIRST: begin
        if (cnt_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          removed_nxt = ent_r[0];
          for (int i = 0; i < DEPTH; i++) begin
            ent_nxt[i] = ent_next[i];
          end
          cnt_nxt = cnt_r - count_t'(1);
        end
      end
      OP_POP_LAST: begin
        if (cnt_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          removed_nxt = last_ent;
          cnt_nxt     = cnt_r - count_t'(1);
        end
      end
      default: begin
        if (cnt_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (!(|eq)) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          // Sorted order puts the first match at the first cell not below
          // the value; that cell and all above it close up.
          removed_nxt = v;
          for (int i = 0; i < DEPTH; i++) begin
            if (ge[i]) begin
              ent_nxt[i] = ent_next[i];
            end
          end
          cnt_nxt = cnt_r - count_t'(1);
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_valid;
      if (cmd_valid) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Entry and result payload.
  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      for (int i = 0; i < DEPTH; i++) begin
        ent_r[i] <= ent_nxt[i];
      end
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
    end
  end

  // Result beat; the end values are read straight from the updated cells.
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_removed_value = 32'(removed_r);
  assign out_entry_count   = 5'(cnt_r);
  assign out_first_value   = (cnt_r != '0) ? 32'(ent_r[0]) : 32'd0;
  assign out_last_value    = (cnt_r != '0) ? 32'(last_ent) : 32'd0;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= count_t'(DEPTH))
    else $error("entry count above depth");

  a_strobe_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |=> out_valid)
    else $error("command without result beat");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status_r == ST_FULL) |-> cnt_r == count_t'(DEPTH))
    else $error("full status with room left");

  a_ends_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (cnt_r != '0) |-> $signed(ent_r[0]) <= $signed(last_ent))
    else $error("first entry above last entry");

  a_ok_changes_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && (status_nxt != ST_OK) |=> $stable(cnt_r))
    else $error("failed request changed the count");

endmodule

FILE: hdl/sorted_double_ended_queue.sv
// Top level of the sorted double-ended queue.
// Depends on sdq_pkg, sdq_front, sdq_fifo and sdq_back.

// A request is taken at a rising edge with start high and busy low; its result
// beat passes the front end's held beat, the command queue and the result
// registers and shows on out_valid for exactly one cycle; the receiver cannot
// stall it, so it must capture every beat. The block sustains one request per
// cycle while busy is low: each cell of the sorted row compares its own entry
// and shifts in the same cycle, so the cell update sets the rate. Results come
// out in request order; a beat's count, first and last values reflect it.
module sorted_double_ended_queue import sdq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_removed_value,
  output logic [4:0]  out_entry_count,
  output logic signed [31:0] out_first_value,
  output logic signed [31:0] out_last_value
);

  logic push;
  cmd_t push_cmd;
  logic fifo_full;
  logic fifo_not_empty;
  cmd_t head;

  // Request intake and decode.
  sdq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req_type(in_req_type),
    .in_value   (in_value),
    .push       (push),
    .push_cmd   (push_cmd),
    .fifo_full  (fifo_full)
  );

  // Decoupling queue; the cell row drains it every cycle.
  sdq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .not_empty(fifo_not_empty),
    .pop      (fifo_not_empty),
    .head     (head)
  );

  // Sorted cell row and result registers.
  sdq_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (fifo_not_empty),
    .cmd              (head),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_entry_count  (out_entry_count),
    .out_first_value  (out_first_value),
    .out_last_value   (out_last_value)
  );

endmodule
